@@ design/insdec_pkg.sv @@
// Shared types and codes for the instruction decoder.
// No dependencies; used by insdec_core, lc4_instruction_decoder, decode_checker and testbench.
`timescale 1ns / 1ps
`default_nettype none
package insdec_pkg;

  localparam int InsWidth = 16;
  localparam int PcWidth  = 16;

  // Top opcode, bits 15:12
  localparam logic [3:0] OP_BR     = 4'd0;
  localparam logic [3:0] OP_CMP    = 4'd2;
  localparam logic [3:0] OP_JSR    = 4'd4;
  localparam logic [3:0] OP_LOGIC  = 4'd5;
  localparam logic [3:0] OP_LDR    = 4'd6;
  localparam logic [3:0] OP_STR    = 4'd7;
  localparam logic [3:0] OP_RTI    = 4'd8;
  localparam logic [3:0] OP_CONST  = 4'd9;
  localparam logic [3:0] OP_SHIFT  = 4'd10;
  localparam logic [3:0] OP_JMP    = 4'd12;
  localparam logic [3:0] OP_HICON  = 4'd13;
  localparam logic [3:0] OP_TRAP   = 4'd15;

  // Dense mnemonic codes
  localparam logic [4:0] MN_NOP     = 5'd0;
  localparam logic [4:0] MN_CMP     = 5'd8;
  localparam logic [4:0] MN_JSRR    = 5'd12;
  localparam logic [4:0] MN_JSR     = 5'd13;
  localparam logic [4:0] MN_AND     = 5'd14;
  localparam logic [4:0] MN_ANDI    = 5'd18;
  localparam logic [4:0] MN_LDR     = 5'd19;
  localparam logic [4:0] MN_STR     = 5'd20;
  localparam logic [4:0] MN_RTI     = 5'd21;
  localparam logic [4:0] MN_CONST   = 5'd22;
  localparam logic [4:0] MN_SLL     = 5'd23;
  localparam logic [4:0] MN_JMPR    = 5'd27;
  localparam logic [4:0] MN_JMP     = 5'd28;
  localparam logic [4:0] MN_HICONST = 5'd29;
  localparam logic [4:0] MN_TRAP    = 5'd30;

  // Logic group sub-codes, bits 5:3
  localparam logic [2:0] LOG_NOT = 3'd1;
  // Compare sub-codes, bits 8:7
  localparam logic [1:0] CMP_CMPI  = 2'd2;
  localparam logic [1:0] CMP_CMPIU = 2'd3;
  // Shift sub-codes, bits 5:4
  localparam logic [1:0] SH_MOD = 2'd3;

  // Address regions
  localparam logic [1:0] REG_CODE    = 2'd0;
  localparam logic [1:0] REG_DATA    = 2'd1;
  localparam logic [1:0] REG_OUTSIDE = 2'd2;
  localparam logic [PcWidth-1:0] CodeLimit = 16'h2000;
  localparam logic [PcWidth-1:0] DataLimit = 16'h8000;

  localparam int ResWidth  = 44;
  localparam int MDataWidth = 48;

  typedef struct packed {
    logic [1:0]         region;
    logic [15:0]        target;
    logic signed [10:0] immediate;
    logic [2:0]         second_reg;
    logic [2:0]         src_reg;
    logic [2:0]         dest_reg;
    logic               invalid;
    logic [4:0]         mnemonic;
  } dec_result_t;

endpackage
`default_nettype wire

@@ design/lc4_instruction_decoder.sv @@
// Top level of the instruction decoder: input register, decode, result register.
// Depends on insdec_pkg and insdec_core.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one beat per instruction:
//   the 16-bit instruction word and the address it sits at.
//   Master channel (m_tvalid/m_tready/m_tdata) gives one beat per instruction:
//   mnemonic code, invalid flag, register fields, extended immediate,
//   branch/jump target and the address region class.
// Path: an accepted input beat passes the input register, the decode logic
//   and the result register before it reaches m_tdata.
// Throughput: 1 beat per cycle, sustained while m_tready stays high.
// Stall: when the receiver holds m_tready low the result register holds its
//   beat; the input register still takes one more beat, after which s_tready
//   drops until the result register drains. Nothing is dropped or repeated.
// Reset: rst (synchronous, active high) empties both registers; s_tready is
//   high in the first cycle after reset. There is no configuration and no
//   other state.
`timescale 1ns / 1ps
`default_nettype none
module lc4_instruction_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] instruction, [31:16] pc
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [4:0] mnemonic, [5] invalid, [8:6] dest_reg, [11:9] src_reg,
  // [14:12] second_reg, [25:15] immediate, [41:26] target, [43:42] region,
  // [47:44] zero
  output logic [insdec_pkg::MDataWidth-1:0] m_tdata
);

  // Input register
  logic                              s1_valid;
  logic [insdec_pkg::InsWidth-1:0]   s1_ins;
  logic [insdec_pkg::PcWidth-1:0]    s1_pc;

  // Result register
  insdec_pkg::dec_result_t dec;
  insdec_pkg::dec_result_t res_q;

  logic adv;   // result register can take a beat this cycle

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || adv;

  insdec_core u_core (
    .instruction (s1_ins),
    .pc          (s1_pc),
    .res         (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) s1_valid <= s_tvalid;
      if (adv)      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_ins <= s_tdata[15:0];
      s1_pc  <= s_tdata[31:16];
    end
    if (adv && s1_valid) res_q <= dec;
  end

  // Struct packs in the same order as the bus fields
  assign m_tdata = {{(insdec_pkg::MDataWidth - insdec_pkg::ResWidth){1'b0}}, res_q};

  // A held input beat moves on as soon as the result register is empty
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !m_tvalid) |=> m_tvalid)
    else $error("input beat not moved into empty result register");

  // Unhandled opcode gives zero mnemonic, target, immediate and dest_reg
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.invalid) |->
      (res_q.mnemonic == insdec_pkg::MN_NOP && res_q.target == 16'd0 &&
       res_q.immediate == 11'sd0 && res_q.dest_reg == 3'd0))
    else $error("invalid opcode with nonzero fields");

  // NOP carries no target
  a_nop_target: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_q.mnemonic == insdec_pkg::MN_NOP) |-> (res_q.target == 16'd0))
    else $error("NOP with nonzero target");

  // Mnemonic stays inside the dense code range
  a_mn_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_q.mnemonic <= insdec_pkg::MN_TRAP))
    else $error("mnemonic out of range");

  // Region class follows the registered address
  a_region: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid) |=>
      (res_q.region == ($past(s1_pc) < insdec_pkg::CodeLimit ? insdec_pkg::REG_CODE :
                        $past(s1_pc) < insdec_pkg::DataLimit ? insdec_pkg::REG_DATA :
                                                               insdec_pkg::REG_OUTSIDE)))
    else $error("region class mismatch");

endmodule
`default_nettype wire

@@ design/insdec_core.sv @@
// Combinational decode of one instruction word and its address.
// Depends on insdec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module insdec_core (
  input  wire logic [insdec_pkg::InsWidth-1:0] instruction,
  input  wire logic [insdec_pkg::PcWidth-1:0]  pc,
  output insdec_pkg::dec_result_t              res
);

  logic [3:0]         op;
  logic [2:0]         rd;
  logic [2:0]         rs;
  logic [2:0]         rt;
  logic signed [10:0] imm9;
  logic signed [10:0] imm11;
  logic [15:0]        br_target;
  logic [15:0]        jmp_target;

  assign op    = instruction[15:12];
  assign rd    = instruction[11:9];
  assign rs    = instruction[8:6];
  assign rt    = instruction[2:0];
  assign imm9  = {{2{instruction[8]}}, instruction[8:0]};
  assign imm11 = instruction[10:0];

  // pc + 1 + offset, wrapping at 16 bits
  assign br_target  = pc + 16'd1 + {{7{instruction[8]}}, instruction[8:0]};
  assign jmp_target = pc + 16'd1 + {{5{instruction[10]}}, instruction[10:0]};

  always_comb begin
    res            = '0;
    res.region     = (pc < insdec_pkg::CodeLimit) ? insdec_pkg::REG_CODE :
                     (pc < insdec_pkg::DataLimit) ? insdec_pkg::REG_DATA :
                                                    insdec_pkg::REG_OUTSIDE;
    unique case (op)
      insdec_pkg::OP_BR: begin
        res.mnemonic = {2'b00, rd};
        if (rd != 3'd0) begin
          res.immediate = imm9;
          res.target    = br_target;
        end
      end
      insdec_pkg::OP_CMP: begin
        res.mnemonic = insdec_pkg::MN_CMP + {3'b000, instruction[8:7]};
        res.src_reg  = rd;
        case (instruction[8:7])
          insdec_pkg::CMP_CMPI:  res.immediate = {{4{instruction[6]}}, instruction[6:0]};
          insdec_pkg::CMP_CMPIU: res.immediate = {4'b0000, instruction[6:0]};
          default:               res.second_reg = rt;
        endcase
      end
      insdec_pkg::OP_JSR: begin
        if (instruction[11]) begin
          res.mnemonic  = insdec_pkg::MN_JSR;
          res.immediate = imm11;
          res.target    = {pc[15], instruction[10:0], 4'b0000};
        end else begin
          res.mnemonic = insdec_pkg::MN_JSRR;
          res.src_reg  = rs;
        end
      end
      insdec_pkg::OP_LOGIC: begin
        res.dest_reg = rd;
        res.src_reg  = rs;
        if (instruction[5]) begin
          res.mnemonic  = insdec_pkg::MN_ANDI;
          res.immediate = {{6{instruction[4]}}, instruction[4:0]};
        end else begin
          res.mnemonic = insdec_pkg::MN_AND + {3'b000, instruction[4:3]};
          if (instruction[5:3] != insdec_pkg::LOG_NOT) res.second_reg = rt;
        end
      end
      insdec_pkg::OP_LDR, insdec_pkg::OP_STR: begin
        res.mnemonic  = (op == insdec_pkg::OP_LDR) ? insdec_pkg::MN_LDR
                                                   : insdec_pkg::MN_STR;
        res.dest_reg  = rd;
        res.src_reg   = rs;
        res.immediate = {{5{instruction[5]}}, instruction[5:0]};
      end
      insdec_pkg::OP_RTI: begin
        res.mnemonic = insdec_pkg::MN_RTI;
      end
      insdec_pkg::OP_CONST: begin
        res.mnemonic  = insdec_pkg::MN_CONST;
        res.dest_reg  = rd;
        res.immediate = imm9;
      end
      insdec_pkg::OP_SHIFT: begin
        res.mnemonic = insdec_pkg::MN_SLL + {3'b000, instruction[5:4]};
        res.dest_reg = rd;
        res.src_reg  = rs;
        if (instruction[5:4] == insdec_pkg::SH_MOD) res.second_reg = rt;
        else res.immediate = {7'b0000000, instruction[3:0]};
      end
      insdec_pkg::OP_JMP: begin
        if (instruction[11]) begin
          res.mnemonic  = insdec_pkg::MN_JMP;
          res.immediate = imm11;
          res.target    = jmp_target;
        end else begin
          res.mnemonic = insdec_pkg::MN_JMPR;
          res.src_reg  = rs;
        end
      end
      insdec_pkg::OP_HICON: begin
        res.mnemonic  = insdec_pkg::MN_HICONST;
        res.dest_reg  = rd;
        res.immediate = {3'b000, instruction[7:0]};
      end
      insdec_pkg::OP_TRAP: begin
        res.mnemonic  = insdec_pkg::MN_TRAP;
        res.immediate = {3'b000, instruction[7:0]};
      end
      default: begin
        res.invalid = 1'b1;  // opcodes 1, 3, 11, 14
      end
    endcase
  end

endmodule
`default_nettype wire

@@ bench/decode_checker.sv @@
// Checker for the instruction decoder: watches both stream channels, predicts each
// result beat from the accepted input beat and compares field by field.
// Depends on insdec_pkg.
`timescale 1ns / 1ps
module decode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [insdec_pkg::MDataWidth-1:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);

  insdec_pkg::dec_result_t due_decodes[$];
  int                      mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic insdec_pkg::dec_result_t decode_word(logic [15:0] word,
                                                          logic [15:0] addr);
    insdec_pkg::dec_result_t res;
    logic [3:0]  op;
    logic [2:0]  rd, rs, rt;
    logic [2:0]  sub3;
    logic [1:0]  sub2;
    res  = '0;
    op   = word[15:12];
    rd   = word[11:9];
    rs   = word[8:6];
    rt   = word[2:0];
    sub3 = word[5:3];
    case (op)
      insdec_pkg::OP_BR: begin
        res.mnemonic = 5'(rd);
        // all condition bits clear: NOP, offset ignored
        if (rd != 3'd0) begin
          res.immediate = {{2{word[8]}}, word[8:0]};
          res.target    = addr + 16'd1 + {{5{res.immediate[10]}}, res.immediate};
        end
      end
      insdec_pkg::OP_CMP: begin
        sub2         = word[8:7];
        res.mnemonic = insdec_pkg::MN_CMP + 5'(sub2);
        res.src_reg  = rd;
        if (sub2 == insdec_pkg::CMP_CMPI)
          res.immediate = {{4{word[6]}}, word[6:0]};
        else if (sub2 == insdec_pkg::CMP_CMPIU)
          res.immediate = {4'b0, word[6:0]};
        else
          res.second_reg = rt;
      end
      insdec_pkg::OP_JSR: begin
        if (word[11]) begin
          res.mnemonic  = insdec_pkg::MN_JSR;
          res.immediate = word[10:0];
          res.target    = {addr[15], word[10:0], 4'b0};
        end else begin
          res.mnemonic = insdec_pkg::MN_JSRR;
          res.src_reg  = rs;
        end
      end
      insdec_pkg::OP_LOGIC: begin
        res.dest_reg = rd;
        res.src_reg  = rs;
        if (sub3[2]) begin
          res.mnemonic  = insdec_pkg::MN_ANDI;
          res.immediate = {{6{word[4]}}, word[4:0]};
        end else begin
          res.mnemonic = insdec_pkg::MN_AND + 5'(sub3);
          if (sub3 != insdec_pkg::LOG_NOT)
            res.second_reg = rt;
        end
      end
      insdec_pkg::OP_LDR, insdec_pkg::OP_STR: begin
        res.mnemonic  = (op == insdec_pkg::OP_LDR) ? insdec_pkg::MN_LDR
                                                   : insdec_pkg::MN_STR;
        res.dest_reg  = rd;
        res.src_reg   = rs;
        res.immediate = {{5{word[5]}}, word[5:0]};
      end
      insdec_pkg::OP_RTI: res.mnemonic = insdec_pkg::MN_RTI;
      insdec_pkg::OP_CONST: begin
        res.mnemonic  = insdec_pkg::MN_CONST;
        res.dest_reg  = rd;
        res.immediate = {{2{word[8]}}, word[8:0]};
      end
      insdec_pkg::OP_SHIFT: begin
        sub2         = word[5:4];
        res.mnemonic = insdec_pkg::MN_SLL + 5'(sub2);
        res.dest_reg = rd;
        res.src_reg  = rs;
        if (sub2 == insdec_pkg::SH_MOD)
          res.second_reg = rt;
        else
          res.immediate = {7'b0, word[3:0]};
      end
      insdec_pkg::OP_JMP: begin
        if (word[11]) begin
          res.mnemonic  = insdec_pkg::MN_JMP;
          res.immediate = word[10:0];
          res.target    = addr + 16'd1 + {{5{word[10]}}, word[10:0]};
        end else begin
          res.mnemonic = insdec_pkg::MN_JMPR;
          res.src_reg  = rs;
        end
      end
      insdec_pkg::OP_HICON: begin
        res.mnemonic  = insdec_pkg::MN_HICONST;
        res.dest_reg  = rd;
        res.immediate = {3'b0, word[7:0]};
      end
      insdec_pkg::OP_TRAP: begin
        res.mnemonic  = insdec_pkg::MN_TRAP;
        res.immediate = {3'b0, word[7:0]};
      end
      default: res.invalid = 1'b1;
    endcase
    if (addr < insdec_pkg::CodeLimit)
      res.region = insdec_pkg::REG_CODE;
    else if (addr < insdec_pkg::DataLimit)
      res.region = insdec_pkg::REG_DATA;
    else
      res.region = insdec_pkg::REG_OUTSIDE;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    insdec_pkg::dec_result_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready)
        due_decodes.push_back(decode_word(s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        got = insdec_pkg::dec_result_t'(m_tdata[insdec_pkg::ResWidth-1:0]);
        if (due_decodes.size() == 0) begin
          $error("result beat with no instruction pending: %0h", m_tdata);
          mismatches++;
        end else begin
          want = due_decodes.pop_front();
          check_field("mnemonic", 16'(want.mnemonic), 16'(got.mnemonic));
          check_field("invalid", 16'(want.invalid), 16'(got.invalid));
          check_field("dest_reg", 16'(want.dest_reg), 16'(got.dest_reg));
          check_field("src_reg", 16'(want.src_reg), 16'(got.src_reg));
          check_field("second_reg", 16'(want.second_reg), 16'(got.second_reg));
          check_field("immediate", 16'(unsigned'(want.immediate)),
                      16'(unsigned'(got.immediate)));
          check_field("target", want.target, got.target);
          check_field("region", 16'(want.region), 16'(got.region));
          check_field("pad", 16'd0,
                      16'(m_tdata[insdec_pkg::MDataWidth-1:insdec_pkg::ResWidth]));
        end
      end
    end
    outstanding <= due_decodes.size();
    fail_count  <= mismatches;
  end

endmodule

@@ bench/testbench.sv @@
// Top of the instruction decoder bench: clock, reset, stimulus, back-pressure
// and the final verdict. Prediction and comparison live in decode_checker.
// Depends on insdec_pkg, decode_checker and lc4_instruction_decoder.
`timescale 1ns / 1ps
module testbench;

  // Opcodes the decoder does not handle; the package has no names for them.
  localparam logic [3:0] OP_RSVD1  = 4'd1;
  localparam logic [3:0] OP_RSVD14 = 4'd14;

  localparam int RandomBeats = 950;
  localparam int PhaseCount  = 3;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 4;
  localparam int ProbeCount  = 30;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [15:0] instruction, [31:16] pc
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [insdec_pkg::MDataWidth-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int quiet_cycles  = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 67;

  // Directed beats, {pc, instruction}: field extremes, every operation, the
  // no-op branch, wrapping targets, region boundaries and unhandled opcodes.
  logic [31:0] probes [ProbeCount] = '{
    {16'h0000, insdec_pkg::OP_BR, 12'h000},      // NOP, everything zero
    {16'h1FFF, insdec_pkg::OP_BR, 12'h1FF},      // NOP with offset bits set, last code address
    {16'h2000, insdec_pkg::OP_BR, 12'hF00},      // BRnzp, most negative offset
    {16'hFFFF, insdec_pkg::OP_BR, 12'h2FF},      // BRp, largest offset, target wraps
    {16'h7FFF, insdec_pkg::OP_CMP, 12'hE07},     // CMP r7, r7
    {16'h8000, insdec_pkg::OP_CMP, 12'h087},     // CMPU, first outside address
    {16'h0001, insdec_pkg::OP_CMP, 12'hF40},     // CMPI most negative
    {16'h4000, insdec_pkg::OP_CMP, 12'h1FF},     // CMPIU largest
    {16'h1234, insdec_pkg::OP_JSR, 12'h1C0},     // JSRR r7
    {16'h8000, insdec_pkg::OP_JSR, 12'hFFF},     // JSR, keeps the top pc bit
    {16'h3000, insdec_pkg::OP_LOGIC, 12'hFC7},   // AND
    {16'h3000, insdec_pkg::OP_LOGIC, 12'h1CF},   // NOT, second register ignored
    {16'h3000, insdec_pkg::OP_LOGIC, 12'hE17},   // OR
    {16'h3000, insdec_pkg::OP_LOGIC, 12'h01F},   // XOR
    {16'h9000, insdec_pkg::OP_LOGIC, 12'hFF0},   // AND immediate, most negative
    {16'h0100, insdec_pkg::OP_LDR, 12'hFE0},     // LDR most negative offset
    {16'h0100, insdec_pkg::OP_STR, 12'h01F},     // STR largest offset
    {16'hABCD, insdec_pkg::OP_RTI, 12'hFFF},     // RTI, all other bits ignored
    {16'h2001, insdec_pkg::OP_CONST, 12'hF00},   // CONST most negative
    {16'h2001, insdec_pkg::OP_SHIFT, 12'hFCF},   // SLL by 15
    {16'h2001, insdec_pkg::OP_SHIFT, 12'hFDF},   // SRA
    {16'h2001, insdec_pkg::OP_SHIFT, 12'hFEF},   // SRL
    {16'h2001, insdec_pkg::OP_SHIFT, 12'hFFF},   // MOD
    {16'h5555, insdec_pkg::OP_JMP, 12'h1C0},     // JMPR
    {16'h0000, insdec_pkg::OP_JMP, 12'hC00},     // JMP most negative, wraps below zero
    {16'hFBFF, insdec_pkg::OP_JMP, 12'hBFF},     // JMP largest
    {16'hFFFF, insdec_pkg::OP_HICON, 12'hEFF},   // HICONST
    {16'h7FFF, insdec_pkg::OP_TRAP, 12'hFFF},    // TRAP
    {16'hFFFF, OP_RSVD1, 12'hFFF},               // unhandled, region still reported
    {16'h0000, OP_RSVD14, 12'h000}               // unhandled
  };

  lc4_instruction_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  decode_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: an independent coin per cycle at the phase's rate.
  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // Watchdog: any accepted beat on either side resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Addresses cluster on the region boundaries and the ends of the space,
  // where the region class flips and targets wrap.
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'hFFFF));
      1: return insdec_pkg::CodeLimit - 16'd2 + 16'($urandom_range(0, 3));
      2: return insdec_pkg::DataLimit - 16'd2 + 16'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                           : 16'hFFFF - 16'($urandom_range(0, 3));
    endcase
  endfunction

  // Present one beat and hold it until the decoder takes it. Idle cycles come
  // first, each with the phase's chance; s_tvalid stays high across back-to-back beats.
  task automatic send_beat(input logic [31:0] beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ProbeCount; i++)
      send_beat(probes[i]);

    // The decoder has no configuration registers to program, so phases only
    // change the idle rates: sender light / receiver heavy, then swapped, then none.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin send_idle_pct = 33; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RandomBeats / PhaseCount; n++)
        send_beat({pick_address(), 16'($urandom_range(0, 16'hFFFF))});
    end
    s_tvalid <= 1'b0;
    // let the checker count the last accepted beat
    @(posedge clk);

    // Drain: the watchdog catches a result that never shows up.
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
